// ----- sv/ebec_pkg.sv -----
// Shared types and constants for the eta-binned energy correction block.
// No dependencies; the queue, front, back end and top level import it.
`default_nettype none
package ebec_pkg;

  localparam int TABLE_BINS_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_LOADED   = 3'd1;
  localparam logic [2:0] ST_OUTSIDE  = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_BELOW    = 3'd4;
  localparam logic [2:0] ST_NEGROOT  = 3'd5;
  localparam logic [2:0] ST_ZERODIV  = 3'd6;

  localparam logic       CMD_LOAD    = 1'b0;
  localparam logic       CMD_CORRECT = 1'b1;

  localparam logic [23:0] ONE_Q8_16  = 24'h010000;

  // One classified word handed from the front to the back.
  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] et;
    logic [31:0] coef_a;
    logic [31:0] coef_b;
    logic [31:0] coef_c;
  } job_t;

endpackage
`default_nettype wire

// ----- sv/ebec_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ebec_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- sv/ebec_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; shared by both divisions of the back end.
`default_nettype none
module ebec_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [58:0] dividend,
  input  wire logic [34:0] divisor,
  output logic             done,
  output logic      [58:0] quotient
);

  logic        busy;
  logic [5:0]  cnt;
  logic [34:0] rem;
  logic [34:0] dvs;
  logic [35:0] rem_sh;
  logic        fits;

  always_comb begin
    rem_sh = {rem, quotient[58]};
    fits   = rem_sh >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      done     <= 1'b0;
      cnt      <= '0;
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? 35'(rem_sh - {1'b0, dvs}) : rem_sh[34:0];
      quotient <= {quotient[57:0], fits};
      cnt      <= cnt + 6'd1;
      if (cnt == 6'd58) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- sv/ebec_queue.sv -----
// Short job queue between the front and the back end.
// Depends on ebec_pkg for the job word type.
`default_nettype none
module ebec_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  ebec_pkg::job_t      push_job,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output ebec_pkg::job_t      head
);
  import ebec_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entry [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = count == CNT_W'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_job;
    end
  end

endmodule
`default_nettype wire

// ----- sv/ebec_front.sv -----
// Front end: takes input words, writes the bin table, searches the edges
// and fetches the chosen bin. Depends on ebec_pkg and ebec_ram.
`default_nettype none
module ebec_front #(
  parameter int TABLE_BINS = ebec_pkg::TABLE_BINS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [5:0]  bins_in_use,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        command,
  input  wire logic [4:0]  bin_index,
  input  wire logic [14:0] bin_edge,
  input  wire logic [31:0] coef_a,
  input  wire logic [31:0] coef_b,
  input  wire logic [31:0] coef_c,
  input  wire logic [14:0] eta_limit,
  input  wire logic [23:0] jet_et,
  input  wire logic [15:0] jet_eta,
  output logic             push,
  output ebec_pkg::job_t   push_job,
  input  wire logic        q_full
);
  import ebec_pkg::*;

  localparam int IDX_W = (TABLE_BINS > 1) ? $clog2(TABLE_BINS) : 1;
  localparam int CNT_W = $clog2(TABLE_BINS + 1);

  localparam logic [1:0] F_IDLE   = 2'd0;
  localparam logic [1:0] F_SEARCH = 2'd1;
  localparam logic [1:0] F_FETCH  = 2'd2;
  localparam logic [1:0] F_PUSH   = 2'd3;

  logic [1:0]       state;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] cnt;
  logic             pend;
  logic [CNT_W-1:0] pend_idx;
  logic             found;
  logic [14:0]      best_edge;
  logic [IDX_W-1:0] sel;
  logic [16:0]      abs_eta;
  logic [23:0]      et;

  logic             accept;
  logic [8:0]       bins_ext;
  logic [8:0]       idx_ext;
  logic [CNT_W-1:0] n_calc;
  logic [16:0]      abs_calc;
  logic             wr_ok;
  logic [14:0]      edge_rd;
  logic [110:0]     bin_rd;
  logic             hit;
  logic [2:0]       fetch_status;

  assign in_ready = (state == F_IDLE) && !q_full;
  assign accept   = in_valid && in_ready;
  assign bins_ext = 9'(bins_in_use);
  assign idx_ext  = 9'(bin_index);
  assign n_calc   = (bins_ext > 9'(TABLE_BINS)) ? CNT_W'(TABLE_BINS) : CNT_W'(bins_ext);
  assign abs_calc = jet_eta[15] ? 17'h10000 - {1'b0, jet_eta} : {1'b0, jet_eta};
  assign wr_ok    = accept && (command == CMD_LOAD) && (idx_ext < 9'(TABLE_BINS));
  assign hit      = ({2'b0, edge_rd} <= abs_eta) && (!found || edge_rd >= best_edge);

  ebec_ram #(.WIDTH(15), .DEPTH(TABLE_BINS)) u_edge_ram (
    .clk     (clk),
    .wr_en   (wr_ok),
    .wr_addr (idx_ext[IDX_W-1:0]),
    .wr_data (bin_edge),
    .rd_addr (cnt[IDX_W-1:0]),
    .rd_data (edge_rd)
  );

  // limit, c, b, a from the top bit down
  ebec_ram #(.WIDTH(111), .DEPTH(TABLE_BINS)) u_bin_ram (
    .clk     (clk),
    .wr_en   (wr_ok),
    .wr_addr (idx_ext[IDX_W-1:0]),
    .wr_data ({eta_limit, coef_c, coef_b, coef_a}),
    .rd_addr (sel),
    .rd_data (bin_rd)
  );

  always_comb begin
    if (!found) begin
      fetch_status = ST_BELOW;
    end else if (abs_eta > {2'b0, bin_rd[110:96]}) begin
      fetch_status = ST_OUTSIDE;
    end else begin
      fetch_status = ST_OK;
    end
  end

  always_comb begin
    push     = 1'b0;
    push_job = '0;
    if (state == F_PUSH) begin
      push            = !q_full;
      push_job.status = fetch_status;
      push_job.et     = et;
      push_job.coef_a = bin_rd[31:0];
      push_job.coef_b = bin_rd[63:32];
      push_job.coef_c = bin_rd[95:64];
    end else if (accept && command == CMD_LOAD) begin
      push            = 1'b1;
      push_job.status = ST_LOADED;
    end else if (accept && n_calc == '0) begin
      push            = 1'b1;
      push_job.status = ST_EMPTY;
      push_job.et     = jet_et;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      pend  <= 1'b0;
      found <= 1'b0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept && command != CMD_LOAD && n_calc != '0) begin
            state   <= F_SEARCH;
            n       <= n_calc;
            cnt     <= '0;
            pend    <= 1'b0;
            found   <= 1'b0;
            abs_eta <= abs_calc;
            et      <= jet_et;
          end
        end
        F_SEARCH: begin
          // issue one edge read a cycle, compare the one read last cycle
          if (cnt != n) begin
            cnt      <= cnt + 1'b1;
            pend     <= 1'b1;
            pend_idx <= cnt;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            if (hit) begin
              found     <= 1'b1;
              best_edge <= edge_rd;
              sel       <= pend_idx[IDX_W-1:0];
            end
            if (pend_idx == n - 1'b1) begin
              state <= F_FETCH;
            end
          end
        end
        F_FETCH: begin
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/ebec_back.sv -----
// Back end: discriminant, square root and the two divisions of one job,
// then the output register. Depends on ebec_pkg and ebec_div.
`default_nettype none
module ebec_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  ebec_pkg::job_t   q_job,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [23:0]      scale,
  output logic [31:0]      corrected_et,
  output logic [2:0]       status
);
  import ebec_pkg::*;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MUL  = 3'd1;
  localparam logic [2:0] B_DISC = 3'd2;
  localparam logic [2:0] B_SQRT = 3'd3;
  localparam logic [2:0] B_DEN  = 3'd4;
  localparam logic [2:0] B_DIV1 = 3'd5;
  localparam logic [2:0] B_DIV2 = 3'd6;
  localparam logic [2:0] B_OUT  = 3'd7;

  logic [2:0]  state;
  logic [5:0]  cnt;
  logic [23:0] et;
  logic [31:0] coef_b;
  logic        diff_neg;
  logic [33:0] dmag;
  logic        tneg;
  logic [31:0] mpl_b;
  logic [63:0] mcand_b;
  logic [63:0] acc_b;
  logic [33:0] mpl_c;
  logic [65:0] mcand_c;
  logic [65:0] acc_c;
  logic [67:0] rad;
  logic [36:0] rem;
  logic [33:0] root;
  logic        neg;
  logic [31:0] etnew;
  logic [23:0] res_scale;
  logic [31:0] res_et;
  logic [2:0]  res_status;
  logic        div_start;
  logic [58:0] div_a;
  logic [34:0] div_d;
  logic        div_done;
  logic [58:0] div_q;

  logic [33:0] job_diff;
  logic [33:0] job_dmag;
  logic [31:0] b_mag;
  logic [31:0] c_mag;
  logic [68:0] term;
  logic [68:0] disc;
  logic [36:0] rem_sh;
  logic [36:0] trial;
  logic [35:0] den;
  logic [34:0] den_mag;
  logic [42:0] q_hi;
  logic [31:0] etnew_c;
  logic [23:0] sc_c;
  logic        out_load;

  always_comb begin
    job_diff = {2'b0, q_job.et, 8'b0} - {{2{q_job.coef_a[31]}}, q_job.coef_a};
    job_dmag = job_diff[33] ? 34'(-job_diff) : job_diff;
    b_mag    = q_job.coef_b[31] ? 32'(-q_job.coef_b) : q_job.coef_b;
    c_mag    = q_job.coef_c[31] ? 32'(-q_job.coef_c) : q_job.coef_c;
    term     = {1'b0, acc_c, 2'b00};
    disc     = {5'b0, acc_b} + (tneg ? 69'(~term + 69'd1) : term);
    rem_sh   = {rem[34:0], rad[67:66]};
    trial    = {1'b0, root, 2'b01};
    den      = {{4{coef_b[31]}}, coef_b} + {2'b0, root};
    den_mag  = den[35] ? 35'(-den) : den[34:0];
    q_hi     = div_q[58:16];
    if (neg) begin
      etnew_c = (q_hi > 43'h0080000000) ? 32'h80000000 : 32'(-q_hi[31:0]);
    end else begin
      etnew_c = (q_hi > 43'h007FFFFFFF) ? 32'h7FFFFFFF : q_hi[31:0];
    end
    if (neg) begin
      sc_c = '0;
    end else if (div_q > 59'h0FFFFFF) begin
      sc_c = 24'hFFFFFF;
    end else begin
      sc_c = div_q[23:0];
    end
  end

  assign q_pop    = (state == B_IDLE) && q_valid;
  assign out_load = (state == B_OUT) && (!out_valid || out_ready);

  ebec_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      scale        <= res_scale;
      corrected_et <= res_et;
      status       <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (q_valid) begin
            et         <= q_job.et;
            coef_b     <= q_job.coef_b;
            res_status <= q_job.status;
            if (q_job.status == ST_LOADED) begin
              res_scale <= '0;
              res_et    <= '0;
              state     <= B_OUT;
            end else if (q_job.status != ST_OK) begin
              res_scale <= ONE_Q8_16;
              res_et    <= {8'b0, q_job.et};
              state     <= B_OUT;
            end else begin
              diff_neg <= job_diff[33];
              dmag     <= job_dmag;
              tneg     <= q_job.coef_c[31] ^ job_diff[33];
              mpl_b    <= b_mag;
              mcand_b  <= {32'b0, b_mag};
              acc_b    <= '0;
              mpl_c    <= job_dmag;
              mcand_c  <= {34'b0, c_mag};
              acc_c    <= '0;
              cnt      <= '0;
              state    <= B_MUL;
            end
          end
        end
        B_MUL: begin
          // shift-add: b*b and c*(et-a) together, one bit a cycle
          if (mpl_b[0]) begin
            acc_b <= acc_b + mcand_b;
          end
          if (mpl_c[0]) begin
            acc_c <= acc_c + mcand_c;
          end
          mpl_b   <= mpl_b >> 1;
          mcand_b <= mcand_b << 1;
          mpl_c   <= mpl_c >> 1;
          mcand_c <= mcand_c << 1;
          cnt     <= cnt + 6'd1;
          if (cnt == 6'd33) begin
            state <= B_DISC;
          end
        end
        B_DISC: begin
          if (disc[68]) begin
            res_scale  <= ONE_Q8_16;
            res_et     <= {8'b0, et};
            res_status <= ST_NEGROOT;
            state      <= B_OUT;
          end else begin
            rad   <= disc[67:0];
            rem   <= '0;
            root  <= '0;
            cnt   <= '0;
            state <= B_SQRT;
          end
        end
        B_SQRT: begin
          // two radicand bits and one root bit a cycle
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[32:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[32:0], 1'b0};
          end
          rad <= rad << 2;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd33) begin
            state <= B_DEN;
          end
        end
        B_DEN: begin
          if (den == '0) begin
            res_scale  <= ONE_Q8_16;
            res_et     <= {8'b0, et};
            res_status <= ST_ZERODIV;
            state      <= B_OUT;
          end else begin
            neg       <= diff_neg ^ den[35];
            div_a     <= {dmag, 25'b0};
            div_d     <= den_mag;
            div_start <= 1'b1;
            state     <= B_DIV1;
          end
        end
        B_DIV1: begin
          // etnew is the shared quotient shifted down; scale divides it by et
          if (div_done) begin
            etnew <= etnew_c;
            if (et == '0) begin
              res_scale  <= ONE_Q8_16;
              res_et     <= etnew_c;
              res_status <= ST_ZERODIV;
              state      <= B_OUT;
            end else begin
              div_a     <= div_q;
              div_d     <= {11'b0, et};
              div_start <= 1'b1;
              state     <= B_DIV2;
            end
          end
        end
        B_DIV2: begin
          if (div_done) begin
            res_scale  <= sc_c;
            res_et     <= etnew;
            res_status <= ST_OK;
            state      <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_load) begin
            state <= B_IDLE;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/eta_binned_energy_correction.sv -----
// Eta-binned jet energy correction, top level.
// Load words (tuser 0) write one bin of the table; correct words (tuser 1)
// carry a jet's et and eta and return scale, corrected et and a status.
// Every input word gives exactly one output word, in order.
// bins_in_use is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while idle, as the block itself has no check for this.
// Front: accepts a word, writes the bin RAMs, scans the edge RAM one bin a
// cycle and fetches the chosen bin. A two-word queue then feeds the back
// end, which runs a shift-add multiply, a square root and two divisions
// on one shared divider. The back end finishes one job before it pops the
// next, which sets the sustained jet rate; words that end early (load,
// empty table, below edge, outside limit) skip its arithmetic.
// The output word sits in a register: a stalled receiver holds it, and the
// back end and the queue keep working until they fill up; then
// s_axis_tready drops.
// Reset (rst, synchronous) clears bins_in_use and all handshake state; the
// table contents are undefined until loaded.
`default_nettype none
module eta_binned_energy_correction #(
  parameter int TABLE_BINS = ebec_pkg::TABLE_BINS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wr_en,
  input  wire logic [5:0]   cfg_wr_data,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // bin_index[4:0] bin_edge[19:5] coef_a[51:20] coef_b[83:52] coef_c[115:84]
  // eta_limit[130:116] jet_et[154:131] jet_eta[170:155], zero fill above
  input  wire logic [175:0] s_axis_tdata,
  // command[0]
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // scale[23:0] corrected_et[55:24] status[58:56], zero fill above
  output logic [63:0]       m_axis_tdata
);
  import ebec_pkg::*;

  logic [5:0]  bins_in_use;
  logic        push;
  job_t        push_job;
  logic        q_full;
  logic        q_pop;
  logic        q_valid;
  job_t        q_head;
  logic [23:0] scale;
  logic [31:0] corrected_et;
  logic [2:0]  status;

  always_ff @(posedge clk) begin
    if (rst) begin
      bins_in_use <= '0;
    end else if (cfg_wr_en) begin
      bins_in_use <= cfg_wr_data;
    end
  end

  ebec_front #(.TABLE_BINS(TABLE_BINS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .bins_in_use (bins_in_use),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .command     (s_axis_tuser),
    .bin_index   (s_axis_tdata[4:0]),
    .bin_edge    (s_axis_tdata[19:5]),
    .coef_a      (s_axis_tdata[51:20]),
    .coef_b      (s_axis_tdata[83:52]),
    .coef_c      (s_axis_tdata[115:84]),
    .eta_limit   (s_axis_tdata[130:116]),
    .jet_et      (s_axis_tdata[154:131]),
    .jet_eta     (s_axis_tdata[170:155]),
    .push        (push),
    .push_job    (push_job),
    .q_full      (q_full)
  );

  ebec_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  ebec_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_job        (q_head),
    .q_pop        (q_pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .scale        (scale),
    .corrected_et (corrected_et),
    .status       (status)
  );

  assign m_axis_tdata = {5'b0, status, corrected_et, scale};

endmodule
`default_nettype wire
